// File: design/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and codes for the format specifier parser: character classes,
// conversion letter indexes and the classified item that crosses the queue.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Character classes assigned by the front end
  localparam logic [3:0] CLS_BAD    = 4'd0;
  localparam logic [3:0] CLS_H      = 4'd1;
  localparam logic [3:0] CLS_L      = 4'd2;
  localparam logic [3:0] CLS_BIGL   = 4'd3;
  localparam logic [3:0] CLS_STAR   = 4'd4;
  localparam logic [3:0] CLS_DOT    = 4'd5;
  localparam logic [3:0] CLS_HASH   = 4'd6;
  localparam logic [3:0] CLS_MINUS  = 4'd7;
  localparam logic [3:0] CLS_SPACE  = 4'd8;
  localparam logic [3:0] CLS_PLUS   = 4'd9;
  localparam logic [3:0] CLS_ZERO   = 4'd10;
  localparam logic [3:0] CLS_DIGIT  = 4'd11;
  localparam logic [3:0] CLS_LETTER = 4'd12;

  // Conversion letter indexes, in the order "csdiuxXopfeEgGn"
  localparam logic [3:0] SP_C     = 4'd0;
  localparam logic [3:0] SP_S     = 4'd1;
  localparam logic [3:0] SP_D     = 4'd2;
  localparam logic [3:0] SP_I     = 4'd3;
  localparam logic [3:0] SP_U     = 4'd4;
  localparam logic [3:0] SP_X     = 4'd5;
  localparam logic [3:0] SP_BIGX  = 4'd6;
  localparam logic [3:0] SP_O     = 4'd7;
  localparam logic [3:0] SP_P     = 4'd8;
  localparam logic [3:0] SP_F     = 4'd9;
  localparam logic [3:0] SP_E     = 4'd10;
  localparam logic [3:0] SP_BIGE  = 4'd11;
  localparam logic [3:0] SP_G     = 4'd12;
  localparam logic [3:0] SP_BIGG  = 4'd13;
  localparam logic [3:0] SP_N     = 4'd14;

  // One classified character; code is the letter index or the digit value
  typedef struct packed {
    logic [3:0]         cls;
    logic [3:0]         code;
    logic signed [31:0] star;
  } item_t;

  // Collection mode of the back end
  typedef struct packed {
    logic in_width;
    logic in_precision;
  } mode_t;

endpackage

// File: design/fsp_queue.sv
// ----------------------------------------------------------------------------
// fsp_queue
// Small circular queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module fsp_queue #(
  parameter int Depth = fsp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  output logic          full,
  input  fsp_pkg::item_t wr_data,
  output logic          rd_valid,
  output fsp_pkg::item_t rd_data,
  input  logic          rd_en
);
  import fsp_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(Depth - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(Depth);

  item_t         entries [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == DEPTH_C);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Store a transfer at the write pointer
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/fsp_front.sv
// ----------------------------------------------------------------------------
// fsp_front
// Input side: classifies each incoming byte and places it in the queue.
// ----------------------------------------------------------------------------
module fsp_front #(
  parameter int QueueDepth = fsp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code,
  input  logic signed [31:0] star_value,
  output logic               q_valid,
  output fsp_pkg::item_t     q_item,
  input  logic               q_pop
);
  import fsp_pkg::*;

  item_t item;

  // Decode the byte into a class and a code
  always_comb begin
    item.star = star_value;
    item.code = '0;
    item.cls  = CLS_BAD;
    unique case (char_code)
      "c": begin item.cls = CLS_LETTER; item.code = SP_C;    end
      "s": begin item.cls = CLS_LETTER; item.code = SP_S;    end
      "d": begin item.cls = CLS_LETTER; item.code = SP_D;    end
      "i": begin item.cls = CLS_LETTER; item.code = SP_I;    end
      "u": begin item.cls = CLS_LETTER; item.code = SP_U;    end
      "x": begin item.cls = CLS_LETTER; item.code = SP_X;    end
      "X": begin item.cls = CLS_LETTER; item.code = SP_BIGX; end
      "o": begin item.cls = CLS_LETTER; item.code = SP_O;    end
      "p": begin item.cls = CLS_LETTER; item.code = SP_P;    end
      "f": begin item.cls = CLS_LETTER; item.code = SP_F;    end
      "e": begin item.cls = CLS_LETTER; item.code = SP_E;    end
      "E": begin item.cls = CLS_LETTER; item.code = SP_BIGE; end
      "g": begin item.cls = CLS_LETTER; item.code = SP_G;    end
      "G": begin item.cls = CLS_LETTER; item.code = SP_BIGG; end
      "n": begin item.cls = CLS_LETTER; item.code = SP_N;    end
      "h": item.cls = CLS_H;
      "l": item.cls = CLS_L;
      "L": item.cls = CLS_BIGL;
      "*": item.cls = CLS_STAR;
      ".": item.cls = CLS_DOT;
      "#": item.cls = CLS_HASH;
      "-": item.cls = CLS_MINUS;
      " ": item.cls = CLS_SPACE;
      "+": item.cls = CLS_PLUS;
      "0": item.cls = CLS_ZERO;
      "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
        item.cls  = CLS_DIGIT;
        item.code = char_code[3:0];
      end
      default: item.cls = CLS_BAD;
    endcase
  end

  // Hold classified items until the back end takes them
  fsp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .full    (full),
    .wr_data (item),
    .rd_valid(q_valid),
    .rd_data (q_item),
    .rd_en   (q_pop)
  );

endmodule

// File: design/fsp_back.sv
// ----------------------------------------------------------------------------
// fsp_back
// Execution side: updates the per-specifier state for each character and, on
// a conversion letter, applies the combination checks into the result register.
// ----------------------------------------------------------------------------
module fsp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  fsp_pkg::item_t     q_item,
  output logic               q_pop,
  output fsp_pkg::mode_t     mode,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         spec_index,
  output logic [4:0]         flag_bits,
  output logic [3:0]         length_bits,
  output logic               width_present,
  output logic signed [31:0] width_value,
  output logic               precision_present,
  output logic signed [31:0] precision_value,
  output logic               format_error
);
  import fsp_pkg::*;

  localparam logic [4:0] F_PLUS  = 5'b00001;
  localparam logic [4:0] F_MINUS = 5'b00010;
  localparam logic [4:0] F_SPACE = 5'b00100;
  localparam logic [4:0] F_ZERO  = 5'b01000;
  localparam logic [4:0] F_HASH  = 5'b10000;
  localparam logic [3:0] L_H  = 4'b0001;
  localparam logic [3:0] L_L  = 4'b0010;
  localparam logic [3:0] L_LL = 4'b0100;
  localparam logic [3:0] L_BL = 4'b1000;

  // Saturating acc * 10 + d on a signed 32-bit accumulator
  function automatic logic signed [31:0] push_digit(logic signed [31:0] acc,
                                                    logic [3:0] d);
    logic signed [35:0] wide;
    logic signed [35:0] x;
    wide = 36'(acc);
    x = (wide <<< 3) + (wide <<< 1) + $signed({32'd0, d});
    if (x > 36'sh0_7FFF_FFFF) begin
      push_digit = 32'sh7FFF_FFFF;
    end else if (x < -36'sh0_8000_0000) begin
      push_digit = 32'sh8000_0000;
    end else begin
      push_digit = x[31:0];
    end
  endfunction

  // Per-specifier state
  logic [4:0]         flag_reg;
  logic [3:0]         length_reg;
  logic               width_set;
  logic signed [31:0] width_acc;
  logic               prec_set;
  logic signed [31:0] prec_acc;
  logic               in_width;
  logic               in_precision;
  logic               star_for_width;
  logic               star_for_precision;
  logic               dot_seen;
  logic               error_seen;

  logic [4:0]         flag_reg_next;
  logic [3:0]         length_reg_next;
  logic               width_set_next;
  logic signed [31:0] width_acc_next;
  logic               prec_set_next;
  logic signed [31:0] prec_acc_next;
  logic               in_width_next;
  logic               in_precision_next;
  logic               star_for_width_next;
  logic               star_for_precision_next;
  logic               char_error;

  logic               out_valid;
  logic               head_conv;
  logic               advance;
  logic               hl_any;
  logic               far_along;
  logic [3:0]         digit;
  logic signed [31:0] pushed;

  // Letter result values
  logic [4:0]         res_flags;
  logic               res_error;
  logic               res_prec_set;

  assign head_conv = (q_item.cls == CLS_LETTER);
  assign advance   = q_valid && !(head_conv && out_valid && !pop);
  assign q_pop     = advance;
  assign empty     = !out_valid;
  assign mode      = '{in_width: in_width, in_precision: in_precision};

  assign hl_any    = |(length_reg & (L_H | L_L | L_BL));
  assign far_along = prec_set || width_set || hl_any;

  // One shared digit unit; width and precision collection never overlap
  assign digit  = (q_item.cls == CLS_DIGIT) ? q_item.code : 4'd0;
  assign pushed = push_digit(in_width ? width_acc : prec_acc, digit);

  // Character step
  always_comb begin
    flag_reg_next           = flag_reg;
    length_reg_next         = length_reg;
    width_set_next          = width_set;
    width_acc_next          = width_acc;
    prec_set_next           = prec_set;
    prec_acc_next           = prec_acc;
    in_width_next           = in_width;
    in_precision_next       = in_precision;
    star_for_width_next     = star_for_width;
    star_for_precision_next = star_for_precision;
    char_error              = 1'b0;
    case (q_item.cls)
      CLS_H, CLS_L, CLS_BIGL: begin
        if (|(length_reg & (L_H | L_BL | L_LL)) ||
            (q_item.cls != CLS_L && |(length_reg & L_L))) begin
          char_error = 1'b1;
        end else begin
          in_precision_next = 1'b0;
          in_width_next     = 1'b0;
          if (q_item.cls == CLS_BIGL) begin
            length_reg_next = length_reg | L_BL;
          end else if (q_item.cls == CLS_H) begin
            length_reg_next = length_reg | L_H;
          end else if (|(length_reg & L_L)) begin
            length_reg_next = length_reg | L_LL;
          end else begin
            length_reg_next = length_reg | L_L;
          end
        end
      end
      CLS_STAR: begin
        if ((in_precision && prec_set) || in_width || hl_any) begin
          char_error = 1'b1;
        end else begin
          if (in_precision) begin
            in_precision_next       = 1'b0;
            star_for_precision_next = 1'b1;
          end else begin
            star_for_width_next = 1'b1;
          end
          if (q_item.star != 32'sd0) begin
            if (star_for_precision_next) begin
              prec_set_next = 1'b1;
              prec_acc_next = q_item.star;
            end else begin
              width_set_next = 1'b1;
              width_acc_next = q_item.star;
            end
          end
        end
      end
      CLS_DOT: begin
        if (in_precision || hl_any) begin
          char_error = 1'b1;
        end else begin
          in_width_next     = 1'b0;
          in_precision_next = 1'b1;
        end
      end
      CLS_HASH: begin
        if (|(flag_reg & F_HASH) || far_along || in_precision || in_width) begin
          char_error = 1'b1;
        end else begin
          flag_reg_next = flag_reg | F_HASH;
        end
      end
      CLS_MINUS: begin
        // Minus drops the zero flag even when it is itself a misuse
        flag_reg_next = flag_reg & ~F_ZERO;
        if (|(flag_reg & F_MINUS) || far_along || in_precision || in_width) begin
          char_error = 1'b1;
        end else begin
          flag_reg_next = (flag_reg & ~F_ZERO) | F_MINUS;
        end
      end
      CLS_SPACE: begin
        if (|(flag_reg & (F_PLUS | F_SPACE)) || far_along || in_precision ||
            in_width) begin
          char_error = 1'b1;
        end else begin
          flag_reg_next = flag_reg | F_SPACE;
        end
      end
      CLS_PLUS: begin
        // Plus drops the space flag even when it is itself a misuse
        flag_reg_next = flag_reg & ~F_SPACE;
        if (|(flag_reg & F_PLUS) || far_along || in_precision || in_width) begin
          char_error = 1'b1;
        end else begin
          flag_reg_next = (flag_reg & ~F_SPACE) | F_PLUS;
        end
      end
      CLS_ZERO: begin
        if ((star_for_width && !in_precision) || star_for_precision) begin
          char_error = 1'b1;
        end else if (in_precision) begin
          prec_set_next = 1'b1;
          prec_acc_next = prec_set ? pushed : 32'sd0;
        end else if (in_width) begin
          width_acc_next = pushed;
        end else if (|(flag_reg & (F_ZERO | F_MINUS)) || far_along) begin
          char_error = 1'b1;
        end else begin
          flag_reg_next = flag_reg | F_ZERO;
        end
      end
      CLS_DIGIT: begin
        if (hl_any || (star_for_width && !in_precision) || star_for_precision) begin
          char_error = 1'b1;
        end else if (in_precision) begin
          prec_set_next = 1'b1;
          prec_acc_next = prec_set ? pushed : $signed({28'd0, q_item.code});
        end else if (in_width || !width_set) begin
          // A stray digit after a finished width is dropped
          in_width_next  = 1'b1;
          width_set_next = 1'b1;
          width_acc_next = width_set ? pushed : $signed({28'd0, q_item.code});
        end
      end
      default: char_error = 1'b1;
    endcase
  end

  // Combination checks on a conversion letter
  always_comb begin
    logic [3:0] sp;
    logic       err;
    sp           = q_item.code;
    res_prec_set = prec_set || dot_seen;
    res_flags    = flag_reg;
    err          = error_seen;
    if (|(res_flags & F_HASH) && !(sp == SP_O || sp == SP_X || sp == SP_BIGX ||
        sp == SP_E || sp == SP_BIGE || sp == SP_F)) begin
      err = 1'b1;
    end
    if (res_prec_set && (sp == SP_C || sp == SP_P)) begin
      err = 1'b1;
    end
    if (|(length_reg & L_H) &&
        (sp == SP_C || sp == SP_S || sp == SP_P || sp == SP_F)) begin
      err = 1'b1;
    end
    if (|(length_reg & L_L) && (sp == SP_P || sp == SP_F)) begin
      err = 1'b1;
    end
    if (|(length_reg & L_BL) && !(sp == SP_E || sp == SP_BIGE || sp == SP_F ||
        sp == SP_G || sp == SP_BIGG)) begin
      err = 1'b1;
    end
    if ((sp == SP_S || sp == SP_C) && |(res_flags & (F_ZERO | F_SPACE | F_PLUS))) begin
      res_flags = res_flags & ~(F_ZERO | F_SPACE | F_PLUS);
      err       = 1'b1;
    end
    if ((|(res_flags & F_MINUS) && |(res_flags & F_ZERO)) ||
        (|(res_flags & F_ZERO) && res_prec_set &&
         (sp == SP_D || sp == SP_I || sp == SP_O || sp == SP_X ||
          sp == SP_BIGX || sp == SP_U || sp == SP_P))) begin
      res_flags = res_flags & ~F_ZERO;
      err       = 1'b1;
    end
    if (|(res_flags & (F_SPACE | F_PLUS)) && sp == SP_U) begin
      err = 1'b1;
    end
    if (|(res_flags & F_SPACE) && |(res_flags & F_PLUS)) begin
      res_flags = res_flags & ~F_SPACE;
      err       = 1'b1;
    end
    res_error = err;
  end

  // Update state; a letter returns everything to its reset values
  always_ff @(posedge clk) begin
    if (rst || (advance && head_conv)) begin
      flag_reg           <= '0;
      length_reg         <= '0;
      width_set          <= 1'b0;
      width_acc          <= '0;
      prec_set           <= 1'b0;
      prec_acc           <= '0;
      in_width           <= 1'b0;
      in_precision       <= 1'b0;
      star_for_width     <= 1'b0;
      star_for_precision <= 1'b0;
      dot_seen           <= 1'b0;
      error_seen         <= 1'b0;
    end else if (advance) begin
      flag_reg           <= flag_reg_next;
      length_reg         <= length_reg_next;
      width_set          <= width_set_next;
      width_acc          <= width_acc_next;
      prec_set           <= prec_set_next;
      prec_acc           <= prec_acc_next;
      in_width           <= in_width_next;
      in_precision       <= in_precision_next;
      star_for_width     <= star_for_width_next;
      star_for_precision <= star_for_precision_next;
      dot_seen           <= dot_seen || in_precision_next;
      error_seen         <= error_seen || char_error;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && head_conv) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (advance && head_conv) begin
      spec_index        <= q_item.code;
      flag_bits         <= res_flags;
      length_bits       <= length_reg;
      width_present     <= width_set;
      width_value       <= width_set ? width_acc : 32'sd0;
      precision_present <= res_prec_set;
      precision_value   <= prec_set ? prec_acc : 32'sd0;
      format_error      <= res_error;
    end
  end

endmodule

// File: design/format_specifier_parser_top.sv
// ----------------------------------------------------------------------------
// format_specifier_parser_top
// Parses the characters after a percent sign and emits one conversion
// description per conversion letter.
//
//   channel  | handshake    | payload
//   ---------+--------------+-----------------------------------------------
//   input    | push / full  | char_code, star_value
//   result   | pop / empty  | spec_index, flag_bits, length_bits,
//            |              | width_present, width_value, precision_present,
//            |              | precision_value, format_error
//
// One character per cycle is accepted while full is low. A result is shown
// on the result ports from the result register: the transfer writes the
// letter into the queue, and once it reaches the queue head and advances,
// the parser state is updated and the result register is loaded.
// rst clears the queue, the parser state and the result valid flag at once.
// A letter waits at the queue head while the result register holds an untaken
// result; characters behind it still enter the queue until full rises.
// ----------------------------------------------------------------------------
module format_specifier_parser_top #(
  parameter int QueueDepth = fsp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code,
  input  logic signed [31:0] star_value,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         spec_index,
  output logic [4:0]         flag_bits,
  output logic [3:0]         length_bits,
  output logic               width_present,
  output logic signed [31:0] width_value,
  output logic               precision_present,
  output logic signed [31:0] precision_value,
  output logic               format_error
);
  import fsp_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  mode_t mode;

  // Classify and queue
  fsp_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .star_value(star_value),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Execute and hold results
  fsp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .mode             (mode),
    .empty            (empty),
    .pop              (pop),
    .spec_index       (spec_index),
    .flag_bits        (flag_bits),
    .length_bits      (length_bits),
    .width_present    (width_present),
    .width_value      (width_value),
    .precision_present(precision_present),
    .precision_value  (precision_value),
    .format_error     (format_error)
  );

  // Width and precision collection never run together
  assert property (@(posedge clk) disable iff (rst)
    !(mode.in_width && mode.in_precision))
    else $error("width and precision collected at once");

  // The back end only stalls on a letter blocked by an untaken result
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_pop) |-> (q_item.cls == CLS_LETTER && !empty && !pop))
    else $error("back end stalled without cause");

  // A queued letter with a free result register produces a result
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_item.cls == CLS_LETTER && empty) |=> !empty)
    else $error("letter did not produce a result");

  // A taken result with no letter behind it leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !(q_valid && q_item.cls == CLS_LETTER)) |=> empty)
    else $error("result repeated after transfer");

  // Reset leaves both sides idle
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

endmodule
